/* hdl/bpt_pkg.sv */
// shared types and constants of the breakpoint table
// slot record, ring control bundle, operation and status codes; no dependencies
package bpt_pkg;

  localparam int Slots = 16;
  localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int AddrW = 32;
  localparam int IdW   = 31;
  localparam int CntW  = 5;
  localparam int FuncW = 2;
  localparam int StatW = 2;

  localparam logic [CntW-1:0] MaxResults = CntW'(16);
  localparam logic [IdW-1:0]  IdMax      = '1;

  localparam logic [FuncW-1:0] FuncAdd    = 2'd0;
  localparam logic [FuncW-1:0] FuncClrId  = 2'd1;
  localparam logic [FuncW-1:0] FuncClrAll = 2'd2;
  localparam logic [FuncW-1:0] FuncList   = 2'd3;

  localparam logic [StatW-1:0] StatusOk       = 2'd0;
  localparam logic [StatW-1:0] StatusFull     = 2'd1;
  localparam logic [StatW-1:0] StatusNotFound = 2'd2;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [IdW-1:0]   id;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic wr;
    logic clr;
  } ring_ctl_t;

endpackage

/* hdl/bpt_cell.sv */
// one slot of the breakpoint ring: holds an address and an identifier
// and passes them to its neighbor on shift; uses bpt_pkg
module bpt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpt_pkg::ring_ctl_t ctl_i,
  input  bpt_pkg::slot_t    next_i,
  input  bpt_pkg::slot_t    wr_i,
  output bpt_pkg::slot_t    slot_o
);

  bpt_pkg::slot_t slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (ctl_i.clr) begin
      slot_d = '0;
    end else if (ctl_i.wr) begin
      slot_d = wr_i;
    end else if (ctl_i.shift) begin
      slot_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

/* hdl/breakpoint_table_top.sv */
// Breakpoint table of Slots entries kept in a ring of cells. Every add,
// clear-by-identifier and list rotates the ring once around (the head cell
// is examined each cycle) and then applies the change in an apply state.
// busy_o is high during the rotation and the apply state, the closing result
// comes in the cycle after, and the next item can be accepted while that
// closing result is shown; clear-all is done from idle and leaves busy_o low.
// Each result is shown for one cycle with valid_o and cannot be held off;
// list results stream out during the rotation, one per active slot up to the
// list limit (capped at MaxResults), the final one flagged by last_o and
// shown as the closing result. Uses bpt_pkg and bpt_cell.
module breakpoint_table_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [bpt_pkg::FuncW-1:0]   func_i,
  input  logic [bpt_pkg::AddrW-1:0]   pc_i,
  input  logic [bpt_pkg::IdW-1:0]     bp_id_i,
  input  logic [bpt_pkg::CntW-1:0]    list_limit_i,
  output logic                        valid_o,
  output logic [bpt_pkg::StatW-1:0]   status_o,
  output logic [bpt_pkg::IdW-1:0]     entry_id_o,
  output logic [bpt_pkg::AddrW-1:0]   entry_pc_o,
  output logic                        entry_valid_o,
  output logic [bpt_pkg::CntW-1:0]    active_count_o,
  output logic                        last_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StApply = 2'd2;

  typedef struct packed {
    logic [bpt_pkg::StatW-1:0] status;
    logic [bpt_pkg::IdW-1:0]   id;
    logic [bpt_pkg::AddrW-1:0] pc;
    logic                      ev;
    logic                      last;
  } res_t;

  function automatic res_t mk_res(logic [bpt_pkg::StatW-1:0] status,
                                  logic [bpt_pkg::IdW-1:0] id,
                                  logic [bpt_pkg::AddrW-1:0] pc,
                                  logic ev, logic last);
    res_t r;
    r.status = status;
    r.id     = id;
    r.pc     = pc;
    r.ev     = ev;
    r.last   = last;
    return r;
  endfunction

  bpt_pkg::slot_t slots [bpt_pkg::Slots];
  bpt_pkg::slot_t head;
  bpt_pkg::slot_t wr_data;
  logic           ring_shift, ring_clr, wr_en;

  logic [1:0]                state_q, state_d;
  logic [bpt_pkg::SlotW-1:0] cnt_q, cnt_d;
  logic                      hit_q, hit_d;
  logic                      free_q, free_d;
  logic                      pend_q, pend_d;
  logic [bpt_pkg::CntW-1:0]  n_q, n_d;
  logic                      valid_q, valid_d;
  logic [bpt_pkg::CntW-1:0]  active_q, active_d;
  logic [bpt_pkg::IdW-1:0]   ctr_q, ctr_d;

  logic [bpt_pkg::FuncW-1:0] func_q, func_d;
  logic [bpt_pkg::AddrW-1:0] pcin_q, pcin_d;
  logic [bpt_pkg::IdW-1:0]   idin_q, idin_d;
  logic [bpt_pkg::CntW-1:0]  lim_q, lim_d;
  logic [bpt_pkg::IdW-1:0]   hit_id_q, hit_id_d;
  logic [bpt_pkg::SlotW-1:0] tgt_q, tgt_d;
  bpt_pkg::slot_t            pend_slot_q, pend_slot_d;
  res_t                      res_q, res_d;

  logic [bpt_pkg::CntW-1:0]  cap;
  logic [bpt_pkg::IdW-1:0]   fresh;

  assign head  = slots[0];
  assign cap   = (lim_q > bpt_pkg::MaxResults) ? bpt_pkg::MaxResults : lim_q;
  assign fresh = (ctr_q == bpt_pkg::IdMax) ? bpt_pkg::IdW'(1) : ctr_q + bpt_pkg::IdW'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    free_d      = free_q;
    pend_d      = pend_q;
    n_d         = n_q;
    valid_d     = 1'b0;
    active_d    = active_q;
    ctr_d       = ctr_q;
    func_d      = func_q;
    pcin_d      = pcin_q;
    idin_d      = idin_q;
    lim_d       = lim_q;
    hit_id_d    = hit_id_q;
    tgt_d       = tgt_q;
    pend_slot_d = pend_slot_q;
    res_d       = res_q;
    ring_shift  = 1'b0;
    ring_clr    = 1'b0;
    wr_en       = 1'b0;
    wr_data     = '0;

    case (state_q)
      StIdle: begin
        if (start_i) begin
          func_d = func_i;
          pcin_d = pc_i;
          idin_d = bp_id_i;
          lim_d  = list_limit_i;
          if (func_i == bpt_pkg::FuncClrAll) begin
            ring_clr = 1'b1;
            active_d = '0;
            valid_d  = 1'b1;
            res_d    = mk_res(bpt_pkg::StatusOk, '0, '0, 1'b0, 1'b1);
          end else begin
            state_d = StScan;
            cnt_d   = '0;
            hit_d   = 1'b0;
            free_d  = 1'b0;
            pend_d  = 1'b0;
            n_d     = '0;
          end
        end
      end
      StScan: begin
        ring_shift = 1'b1;
        cnt_d      = cnt_q + bpt_pkg::SlotW'(1);
        if (cnt_q == bpt_pkg::SlotW'(bpt_pkg::Slots - 1)) begin
          state_d = StApply;
        end
        case (func_q)
          bpt_pkg::FuncAdd: begin
            if (!hit_q && head.id != '0 && head.addr == pcin_q) begin
              hit_d    = 1'b1;
              hit_id_d = head.id;
            end
            if (!free_q && head.id == '0) begin
              free_d = 1'b1;
              tgt_d  = cnt_q;
            end
          end
          bpt_pkg::FuncClrId: begin
            if (!hit_q && idin_q != '0 && head.id == idin_q) begin
              hit_d = 1'b1;
              tgt_d = cnt_q;
            end
          end
          bpt_pkg::FuncList: begin
            if (head.id != '0 && n_q < cap) begin
              if (pend_q) begin
                valid_d = 1'b1;
                res_d   = mk_res(bpt_pkg::StatusOk, pend_slot_q.id, pend_slot_q.addr,
                                 1'b1, 1'b0);
              end
              pend_d      = 1'b1;
              pend_slot_d = head;
              n_d         = n_q + bpt_pkg::CntW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      StApply: begin
        state_d = StIdle;
        valid_d = 1'b1;
        case (func_q)
          bpt_pkg::FuncAdd: begin
            if (hit_q) begin
              res_d = mk_res(bpt_pkg::StatusOk, hit_id_q, '0, 1'b0, 1'b1);
            end else if (free_q) begin
              wr_en        = 1'b1;
              wr_data.addr = pcin_q;
              wr_data.id   = fresh;
              ctr_d        = fresh;
              active_d     = active_q + bpt_pkg::CntW'(1);
              res_d        = mk_res(bpt_pkg::StatusOk, fresh, '0, 1'b0, 1'b1);
            end else begin
              res_d = mk_res(bpt_pkg::StatusFull, '0, '0, 1'b0, 1'b1);
            end
          end
          bpt_pkg::FuncClrId: begin
            if (hit_q) begin
              wr_en    = 1'b1;
              active_d = active_q - bpt_pkg::CntW'(1);
              res_d    = mk_res(bpt_pkg::StatusOk, '0, '0, 1'b0, 1'b1);
            end else begin
              res_d = mk_res(bpt_pkg::StatusNotFound, '0, '0, 1'b0, 1'b1);
            end
          end
          default: begin
            if (pend_q) begin
              res_d = mk_res(bpt_pkg::StatusOk, pend_slot_q.id, pend_slot_q.addr,
                             1'b1, 1'b1);
            end else begin
              res_d = mk_res(bpt_pkg::StatusOk, '0, '0, 1'b0, 1'b1);
            end
          end
        endcase
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      pend_q   <= 1'b0;
      n_q      <= '0;
      valid_q  <= 1'b0;
      active_q <= '0;
      ctr_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
      pend_q   <= pend_d;
      n_q      <= n_d;
      valid_q  <= valid_d;
      active_q <= active_d;
      ctr_q    <= ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    pcin_q      <= pcin_d;
    idin_q      <= idin_d;
    lim_q       <= lim_d;
    hit_id_q    <= hit_id_d;
    tgt_q       <= tgt_d;
    pend_slot_q <= pend_slot_d;
    res_q       <= res_d;
  end

  for (genvar i = 0; i < bpt_pkg::Slots; i++) begin : g_cell
    bpt_pkg::ring_ctl_t ctl;
    assign ctl.shift = ring_shift;
    assign ctl.clr   = ring_clr;
    assign ctl.wr    = wr_en && (tgt_q == bpt_pkg::SlotW'(i));
    bpt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .next_i (slots[(i + 1) % bpt_pkg::Slots]),
      .wr_i   (wr_data),
      .slot_o (slots[i])
    );
  end

  assign busy_o         = (state_q != StIdle);
  assign valid_o        = valid_q;
  assign status_o       = res_q.status;
  assign entry_id_o     = res_q.id;
  assign entry_pc_o     = res_q.pc;
  assign entry_valid_o  = res_q.ev;
  assign active_count_o = active_q;
  assign last_o         = res_q.last;

`ifndef SYNTH
  // results shown while busy are mid-list entries, the closing one comes when idle
  a_last_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_o == !busy_o))
    else $error("last flag does not match busy");

  a_mid_is_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> entry_valid_o)
    else $error("non-final result without an entry");

  a_empty_no_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !entry_valid_o) |-> (entry_pc_o == '0))
    else $error("address on a result without an entry");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == bpt_pkg::StatusOk || status_o == bpt_pkg::StatusFull ||
                 status_o == bpt_pkg::StatusNotFound))
    else $error("bad status code");

  a_apply_after_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StApply) |-> ($past(state_q) == StScan &&
                              $past(cnt_q) == bpt_pkg::SlotW'(bpt_pkg::Slots - 1)))
    else $error("apply without a full rotation");
`endif

endmodule

/* test/tb_breakpoint_table_top.sv */
// self-checking testbench for breakpoint_table_top: directed and random command items
// checked against a local model of the slot table; needs bpt_pkg and the table rtl
module tb_breakpoint_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int TailCycles = 40;
  localparam int PoolSize   = 24;

  typedef struct packed {
    logic [bpt_pkg::StatW-1:0] status;
    logic [bpt_pkg::IdW-1:0]   id;
    logic [bpt_pkg::AddrW-1:0] pc;
    logic                      valid;
    logic [bpt_pkg::CntW-1:0]  count;
    logic                      last_flag;
  } bp_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic [bpt_pkg::FuncW-1:0] func_i;
  logic [bpt_pkg::AddrW-1:0] pc_i;
  logic [bpt_pkg::IdW-1:0]   bp_id_i;
  logic [bpt_pkg::CntW-1:0]  list_limit_i;
  logic                      valid_o;
  logic [bpt_pkg::StatW-1:0] status_o;
  logic [bpt_pkg::IdW-1:0]   entry_id_o;
  logic [bpt_pkg::AddrW-1:0] entry_pc_o;
  logic                      entry_valid_o;
  logic [bpt_pkg::CntW-1:0]  active_count_o;
  logic                      last_o;

  // local copy of the table
  logic [bpt_pkg::AddrW-1:0] tbl_addr [bpt_pkg::Slots];
  logic [bpt_pkg::IdW-1:0]   tbl_id [bpt_pkg::Slots];
  logic [bpt_pkg::IdW-1:0]   id_counter;
  logic [bpt_pkg::CntW-1:0]  tbl_count;

  bp_result_t                pending_results[$];
  logic [bpt_pkg::AddrW-1:0] pc_pool [PoolSize];

  int fail_count;
  int items_sent;
  int results_checked;
  int full_seen;
  int not_found_seen;
  int idle_pct;
  int cycle_count;

  breakpoint_table_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .pc_i           (pc_i),
    .bp_id_i        (bp_id_i),
    .list_limit_i   (list_limit_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .entry_id_o     (entry_id_o),
    .entry_pc_o     (entry_pc_o),
    .entry_valid_o  (entry_valid_o),
    .active_count_o (active_count_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void predict_item(input logic [bpt_pkg::FuncW-1:0] f,
                                       input logic [bpt_pkg::AddrW-1:0] pc,
                                       input logic [bpt_pkg::IdW-1:0] id,
                                       input logic [bpt_pkg::CntW-1:0] lim);
    bp_result_t res;
    logic       hit;
    int         cap;
    int         n;
    res = '0;
    res.last_flag = 1'b1;
    hit = 1'b0;
    case (f)
      bpt_pkg::FuncAdd: begin
        for (int i = 0; i < bpt_pkg::Slots; i++) begin
          if (!hit && tbl_id[i] != '0 && tbl_addr[i] == pc) begin
            hit = 1'b1;
            res.id = tbl_id[i];
          end
        end
        for (int i = 0; i < bpt_pkg::Slots; i++) begin
          if (!hit && tbl_id[i] == '0) begin
            hit = 1'b1;
            id_counter = (id_counter == bpt_pkg::IdMax) ? bpt_pkg::IdW'(1)
                                                        : id_counter + bpt_pkg::IdW'(1);
            tbl_addr[i] = pc;
            tbl_id[i] = id_counter;
            tbl_count = tbl_count + bpt_pkg::CntW'(1);
            res.id = id_counter;
          end
        end
        if (!hit) res.status = bpt_pkg::StatusFull;
        res.count = tbl_count;
        pending_results.push_back(res);
      end
      bpt_pkg::FuncClrId: begin
        res.status = bpt_pkg::StatusNotFound;
        for (int i = 0; i < bpt_pkg::Slots; i++) begin
          if (!hit && id != '0 && tbl_id[i] == id) begin
            hit = 1'b1;
            tbl_id[i] = '0;
            tbl_addr[i] = '0;
            tbl_count = tbl_count - bpt_pkg::CntW'(1);
            res.status = bpt_pkg::StatusOk;
          end
        end
        res.count = tbl_count;
        pending_results.push_back(res);
      end
      bpt_pkg::FuncClrAll: begin
        for (int i = 0; i < bpt_pkg::Slots; i++) begin
          tbl_id[i] = '0;
          tbl_addr[i] = '0;
        end
        tbl_count = '0;
        pending_results.push_back(res);
      end
      default: begin
        cap = (lim > bpt_pkg::MaxResults) ? int'(bpt_pkg::MaxResults) : int'(lim);
        n = 0;
        for (int i = 0; i < bpt_pkg::Slots; i++) begin
          if (n < cap && tbl_id[i] != '0) begin
            res.status = bpt_pkg::StatusOk;
            res.id = tbl_id[i];
            res.pc = tbl_addr[i];
            res.valid = 1'b1;
            res.count = tbl_count;
            res.last_flag = 1'b0;
            pending_results.push_back(res);
            n++;
          end
        end
        if (n == 0) begin
          res.count = tbl_count;
          pending_results.push_back(res);
        end else begin
          pending_results[pending_results.size()-1].last_flag = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    bp_result_t want;
    if (rst_ni === 1'b1 && valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no item waiting for it: status %0h id %0h", status_o, entry_id_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status == bpt_pkg::StatusFull) full_seen++;
        if (want.status == bpt_pkg::StatusNotFound) not_found_seen++;
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("entry_id", 32'(want.id), 32'(entry_id_o));
        check_field("entry_pc", want.pc, entry_pc_o);
        check_field("entry_valid", 32'(want.valid), 32'(entry_valid_o));
        check_field("active_count", 32'(want.count), 32'(active_count_o));
        check_field("last", 32'(want.last_flag), 32'(last_o));
      end
    end
  end

  task automatic send_item(input logic [bpt_pkg::FuncW-1:0] f,
                           input logic [bpt_pkg::AddrW-1:0] pc,
                           input logic [bpt_pkg::IdW-1:0] id,
                           input logic [bpt_pkg::CntW-1:0] lim);
    start_i      <= 1'b1;
    func_i       <= f;
    pc_i         <= pc;
    bp_id_i      <= id;
    list_limit_i <= lim;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_item(f, pc, id, lim);
    items_sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  endtask

  task automatic wait_results_done();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_item(bpt_pkg::FuncList, $urandom(), bpt_pkg::IdW'($urandom()),
              bpt_pkg::CntW'(16));
    send_item(bpt_pkg::FuncClrId, $urandom(), '0, bpt_pkg::CntW'($urandom_range(16)));
    send_item(bpt_pkg::FuncClrId, $urandom(), bpt_pkg::IdMax,
              bpt_pkg::CntW'($urandom_range(16)));
  endtask

  task automatic test_fill_and_full();
    logic [31:0]               r;
    logic [bpt_pkg::AddrW-1:0] pc;
    for (int k = 0; k < bpt_pkg::Slots; k++) begin
      r = $urandom();
      pc = (k == 0) ? '0 : (k == 1) ? '1 : {4'(k - 1), r[27:0]};
      send_item(bpt_pkg::FuncAdd, pc, bpt_pkg::IdW'($urandom()),
                bpt_pkg::CntW'($urandom_range(16)));
    end
    send_item(bpt_pkg::FuncAdd, 32'h1234_5678, bpt_pkg::IdW'($urandom()),
              bpt_pkg::CntW'($urandom_range(16)));
    send_item(bpt_pkg::FuncAdd, '0, bpt_pkg::IdW'($urandom()),
              bpt_pkg::CntW'($urandom_range(16)));
    send_item(bpt_pkg::FuncList, $urandom(), bpt_pkg::IdW'($urandom()),
              bpt_pkg::CntW'(16));
    send_item(bpt_pkg::FuncList, $urandom(), bpt_pkg::IdW'($urandom()), '0);
  endtask

  task automatic test_clear_and_reuse();
    send_item(bpt_pkg::FuncClrId, $urandom(), bpt_pkg::IdW'(3),
              bpt_pkg::CntW'($urandom_range(16)));
    send_item(bpt_pkg::FuncClrId, $urandom(), bpt_pkg::IdW'(3),
              bpt_pkg::CntW'($urandom_range(16)));
    send_item(bpt_pkg::FuncAdd, 32'hCAFE_0000, bpt_pkg::IdW'($urandom()),
              bpt_pkg::CntW'($urandom_range(16)));
    send_item(bpt_pkg::FuncList, $urandom(), bpt_pkg::IdW'($urandom()),
              bpt_pkg::CntW'(5));
    send_item(bpt_pkg::FuncClrAll, $urandom(), bpt_pkg::IdW'($urandom()),
              bpt_pkg::CntW'($urandom_range(16)));
    wait_results_done();
  endtask

  task automatic test_random_traffic(input int count, input int pct);
    logic [bpt_pkg::IdW-1:0]   live_ids[$];
    logic [bpt_pkg::AddrW-1:0] pc;
    logic [bpt_pkg::IdW-1:0]   id;
    int                        pick;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      pc = ($urandom_range(3) != 0) ? pc_pool[$urandom_range(PoolSize - 1)] : $urandom();
      id = bpt_pkg::IdW'($urandom());
      if (pick < 45) begin
        send_item(bpt_pkg::FuncAdd, pc, id, bpt_pkg::CntW'($urandom_range(16)));
      end else if (pick < 70) begin
        live_ids.delete();
        for (int i = 0; i < bpt_pkg::Slots; i++) begin
          if (tbl_id[i] != '0) live_ids.push_back(tbl_id[i]);
        end
        if (live_ids.size() != 0 && $urandom_range(9) < 8) begin
          id = live_ids[$urandom_range(live_ids.size() - 1)];
        end else if ($urandom_range(1) == 0) begin
          id = '0;
        end
        send_item(bpt_pkg::FuncClrId, pc, id, bpt_pkg::CntW'($urandom_range(16)));
      end else if (pick < 73) begin
        send_item(bpt_pkg::FuncClrAll, pc, id, bpt_pkg::CntW'($urandom_range(16)));
      end else begin
        send_item(bpt_pkg::FuncList, pc, id, bpt_pkg::CntW'($urandom_range(16)));
      end
    end
    wait_results_done();
  endtask

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    func_i       = bpt_pkg::FuncAdd;
    pc_i         = '0;
    bp_id_i      = '0;
    list_limit_i = '0;
    fail_count   = 0;
    items_sent   = 0;
    idle_pct     = 0;
    cycle_count  = 0;
    for (int i = 0; i < bpt_pkg::Slots; i++) begin
      tbl_addr[i] = '0;
      tbl_id[i]   = '0;
    end
    id_counter = '0;
    tbl_count  = '0;
    for (int i = 0; i < PoolSize; i++) pc_pool[i] = $urandom();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_fill_and_full();
    test_clear_and_reuse();
    test_random_traffic(137, 26);
    test_random_traffic(137, 66);
    test_random_traffic(136, 0);

    repeat (TailCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    $display("sent %0d items (add, clear, clear-all, list), checked %0d results", items_sent,
             results_checked);
    $display("table-full responses: %0d, identifier-not-found responses: %0d", full_seen,
             not_found_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
